/* rtl/lpe_pkg.sv */
// shared types, constants and helper functions of the line position estimator
`timescale 1ns / 1ps
package lpe_pkg;

  localparam int NUM_SENSORS_DEF = 8;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FIELD_W         = 12;
  localparam int NUM_FIELDS      = 8;
  localparam int CFG_W           = 12;
  localparam int POS_W           = 13;
  localparam int WGT_W           = 14;
  localparam int OP_W            = 3;
  localparam int CIDX_W          = 3;

  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_TRACK    = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_MAX = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_MIN = 3'd3;
  localparam logic [OP_W-1:0] OP_MEASURE  = 3'd4;

  localparam logic [CIDX_W-1:0] CFG_LINE_LEVEL     = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TRACK_LEVEL    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_LINE_THRESHOLD = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LINE_IS_LIGHT  = 3'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] sample_0;
    logic [FIELD_W-1:0] sample_1;
    logic [FIELD_W-1:0] sample_2;
    logic [FIELD_W-1:0] sample_3;
    logic [FIELD_W-1:0] sample_4;
    logic [FIELD_W-1:0] sample_5;
    logic [FIELD_W-1:0] sample_6;
    logic [FIELD_W-1:0] sample_7;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    line_seen;
    logic                    calibration_error;
  } out_t;

  // mapping endpoints and clamp levels shared by all lanes
  typedef struct packed {
    logic [CFG_W-1:0] a;
    logic [CFG_W-1:0] b;
    logic [CFG_W-1:0] track;
    logic [CFG_W-1:0] line;
  } lane_cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LANE,
    S_MERGE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_ACC,
    M_FIN,
    M_DIV
  } mstate_t;

  function automatic logic [FIELD_W-1:0] sample_of(in_t d, int i);
    case (i)
      0: sample_of = d.sample_0;
      1: sample_of = d.sample_1;
      2: sample_of = d.sample_2;
      3: sample_of = d.sample_3;
      4: sample_of = d.sample_4;
      5: sample_of = d.sample_5;
      6: sample_of = d.sample_6;
      7: sample_of = d.sample_7;
      default: sample_of = '0;
    endcase
  endfunction

  function automatic logic signed [WGT_W-1:0] weight_of(int i, int ns);
    return WGT_W'((ns - 1) * 500 - 1000 * i);
  endfunction

endpackage

/* rtl/lpe_div.sv */
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module lpe_div import lpe_pkg::*; #(
  parameter int NW = 24,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    q_r;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DW:0]      trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, q_r[NW-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

/* rtl/lpe_lane.sv */
// one sensor lane: linear map from calibrated range, truncating divide, clamp
`timescale 1ns / 1ps
module lpe_lane import lpe_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] x,
  input  logic [SAMPLE_BITS-1:0] lo,
  input  logic [SAMPLE_BITS-1:0] hi,
  input  lane_cfg_t              cfg,
  output logic                   done,
  output logic [CFG_W-1:0]       v
);
  localparam int SB = SAMPLE_BITS;
  localparam int NW = SB + CFG_W;
  localparam int PW = SB + CFG_W + 2;
  localparam int VW = NW + 2;

  logic                 s1_r, s2_r, done_r, neg_r;
  logic signed [SB:0]   diff_r;
  logic [SB-1:0]        den_r;
  logic signed [CFG_W:0] span;
  logic signed [PW-1:0] prod_r;
  logic [PW-1:0]        prod_abs;
  logic [NW-1:0]        quo;
  logic                 div_done;
  logic signed [VW-1:0] qs, vfull, vlo, vclamp;
  logic [CFG_W-1:0]     v_r;

  assign span     = $signed({1'b0, cfg.b}) - $signed({1'b0, cfg.a});
  assign prod_abs = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      done_r <= div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff_r <= $signed({1'b0, x}) - $signed({1'b0, lo});
      den_r  <= hi - lo;
    end
    if (s1_r) prod_r <= PW'(diff_r * span);
    if (s2_r) neg_r  <= prod_r[PW-1];
    if (div_done) v_r <= vclamp[CFG_W-1:0];
  end

  lpe_div #(.NW(NW), .DW(SB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (s2_r),
    .num   (prod_abs[NW-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  // raise to track level first, then cap at line level
  always_comb begin
    qs     = neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    vfull  = qs + $signed(VW'(cfg.a));
    vlo    = (vfull < $signed(VW'(cfg.track))) ? $signed(VW'(cfg.track)) : vfull;
    vclamp = (vlo > $signed(VW'(cfg.line))) ? $signed(VW'(cfg.line)) : vlo;
  end

  assign done = done_r;
  assign v    = v_r;
endmodule

/* rtl/lpe_merge.sv */
// merge stage: weighted sum over lanes, threshold check, mean by division
`timescale 1ns / 1ps
module lpe_merge import lpe_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [NUM_SENSORS-1:0][CFG_W-1:0] vals,
  input  logic [CFG_W-1:0]                  thr,
  input  logic signed [WGT_W-1:0]           last_pos,
  output logic                              done,
  output logic signed [WGT_W-1:0]           position,
  output logic                              seen
);
  localparam int NS   = NUM_SENSORS;
  localparam int IW   = $clog2(NS);
  localparam int SUMW = CFG_W + WGT_W + $clog2(NS);
  localparam int TW   = CFG_W + $clog2(NS);
  localparam logic signed [WGT_W-1:0] W0 = weight_of(0, NS);

  mstate_t state_r, state_nxt;
  logic [IW-1:0]          idx_r;
  logic signed [SUMW-1:0] sum_r;
  logic [TW-1:0]          total_r;
  logic                   seen_r, done_r, neg_r;
  logic signed [WGT_W-1:0] pos_r;
  logic [CFG_W-1:0]       cur;
  logic signed [CFG_W+WGT_W:0] term;
  logic                   go_div, div_done;
  logic [SUMW-1:0]        sum_abs, quo;

  assign cur     = vals[idx_r];
  assign term    = $signed({1'b0, cur}) * weight_of(int'(idx_r), NS);
  assign sum_abs = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (start) state_nxt = M_ACC;
      M_ACC:   if (idx_r == IW'(NS - 1)) state_nxt = M_FIN;
      M_FIN:   state_nxt = go_div ? M_DIV : M_IDLE;
      M_DIV:   if (div_done) state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    go_div = (state_r == M_FIN) && seen_r && (total_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == M_FIN) && !go_div) || ((state_r == M_DIV) && div_done);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      M_IDLE: begin
        idx_r   <= '0;
        sum_r   <= '0;
        total_r <= '0;
        seen_r  <= 1'b0;
      end
      M_ACC: begin
        idx_r   <= idx_r + 1'b1;
        sum_r   <= sum_r + SUMW'(term);
        total_r <= total_r + TW'(cur);
        if (cur > thr) seen_r <= 1'b1;
      end
      M_FIN: begin
        neg_r <= sum_r[SUMW-1];
        if (!go_div) begin
          seen_r <= 1'b0;
          // no line: snap to the outer weight nearer the last position
          pos_r  <= (last_pos > 0) ? W0 : -W0;
        end
      end
      M_DIV: begin
        if (div_done) pos_r <= neg_r ? -$signed(quo[WGT_W-1:0]) : $signed(quo[WGT_W-1:0]);
      end
      default: ;
    endcase
  end

  lpe_div #(.NW(SUMW), .DW(TW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_div),
    .num   (sum_abs),
    .den   (total_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign done     = done_r;
  assign position = pos_r;
  assign seen     = seen_r;
endmodule

/* rtl/line_position_estimator_top.sv */
// top level of the line position estimator: calibration store, lanes, merge, handshakes
//
//   channel  dir  ports                        moves
//   in       in   in_valid/in_ready/in_data    opcode and one frame of samples
//   out      out  out_valid/out_ready/out_data position, line seen, calibration error
//   cfg      in   cfg_valid/cfg_ready/cfg_*    register index and write data
//
// calibration opcodes update the store in the accept cycle, out_valid rises once the output register is free
// measure: lane map pipeline, then lane divider, then merge sweep over the lanes, then mean divider
//   when a line is seen, one frame at a time
// reset is synchronous active low; restores registers, min/max store and last position
// a new frame is taken while the previous result still waits in the output register
// cfg_ready is always high; writes are expected only while the block is idle
`timescale 1ns / 1ps
module line_position_estimator_top import lpe_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);
  localparam int NS = NUM_SENSORS;
  localparam int SB = SAMPLE_BITS;

  state_t state_r, state_nxt;

  // configuration registers
  logic [CFG_W-1:0] line_level_r, track_level_r, line_thr_r;
  logic             line_light_r;

  // calibration store
  logic [SB-1:0] min_r [NS];
  logic [SB-1:0] max_r [NS];
  logic [SB-1:0] samp  [NS];

  logic signed [WGT_W-1:0] last_pos_r;
  logic                    seen_r;
  logic                    cal_bad;
  logic                    in_accept, is_measure, lane_start, out_free, out_load;
  logic                    out_valid_r;
  out_t                    out_r;
  lane_cfg_t               lcfg;
  logic [NS-1:0]           lane_done;
  logic [NS-1:0][CFG_W-1:0] lane_v;
  logic                    merge_start, merge_done, merge_seen;
  logic signed [WGT_W-1:0] merge_pos;

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_valid && in_ready;
  assign is_measure = (in_data.opcode == OP_MEASURE);
  assign out_free   = !out_valid_r || out_ready;

  // samples beyond the input fields read zero, then fit to sample width
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      samp[i] = SB'(16'(sample_of(in_data, i)));
    end
  end

  always_comb begin
    cal_bad = 1'b0;
    for (int i = 0; i < NS; i++) begin
      if (min_r[i] >= max_r[i]) cal_bad = 1'b1;
    end
  end

  // polarity picks which level the stored min maps to
  always_comb begin
    lcfg.a     = line_light_r ? track_level_r : line_level_r;
    lcfg.b     = line_light_r ? line_level_r : track_level_r;
    lcfg.track = track_level_r;
    lcfg.line  = line_level_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = (is_measure && !cal_bad) ? S_LANE : S_DONE;
      end
      S_LANE:  if (&lane_done) state_nxt = S_MERGE;
      S_MERGE: if (merge_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready    = (state_r == S_IDLE);
    lane_start  = (state_r == S_IDLE) && in_valid && is_measure && !cal_bad;
    merge_start = (state_r == S_LANE) && (&lane_done);
    out_load    = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_level_r  <= CFG_W'(1000);
      track_level_r <= '0;
      line_thr_r    <= CFG_W'(700);
      line_light_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LINE_LEVEL:     line_level_r  <= cfg_data;
        CFG_TRACK_LEVEL:    track_level_r <= cfg_data;
        CFG_LINE_THRESHOLD: line_thr_r    <= cfg_data;
        CFG_LINE_IS_LIGHT:  line_light_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // calibration opcodes update the store in the accept cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        min_r[i] <= '1;
        max_r[i] <= '0;
      end
    end else if (in_accept) begin
      case (in_data.opcode)
        OP_CLEAR: begin
          for (int i = 0; i < NS; i++) begin
            min_r[i] <= '1;
            max_r[i] <= '0;
          end
        end
        OP_TRACK: begin
          for (int i = 0; i < NS; i++) begin
            if (samp[i] > max_r[i]) max_r[i] <= samp[i];
            if (samp[i] < min_r[i]) min_r[i] <= samp[i];
          end
        end
        OP_LOAD_MAX: for (int i = 0; i < NS; i++) max_r[i] <= samp[i];
        OP_LOAD_MIN: for (int i = 0; i < NS; i++) min_r[i] <= samp[i];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      seen_r     <= 1'b0;
    end else if (in_accept) begin
      seen_r <= 1'b0;
    end else if (merge_done) begin
      last_pos_r <= merge_pos;
      seen_r     <= merge_seen;
    end
  end

  // result register; error flag reflects the store after the transaction
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.position          <= last_pos_r[POS_W-1:0];
      out_r.line_seen         <= seen_r;
      out_r.calibration_error <= cal_bad;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar g = 0; g < NS; g++) begin : g_lane
    lpe_lane #(.SAMPLE_BITS(SB)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .x     (samp[g]),
      .lo    (min_r[g]),
      .hi    (max_r[g]),
      .cfg   (lcfg),
      .done  (lane_done[g]),
      .v     (lane_v[g])
    );
  end

  lpe_merge #(.NUM_SENSORS(NS)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (merge_start),
    .vals     (lane_v),
    .thr      (line_thr_r),
    .last_pos (last_pos_r),
    .done     (merge_done),
    .position (merge_pos),
    .seen     (merge_seen)
  );

  // lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done != '0) |-> (&lane_done))
    else $error("lanes finished out of step");

  a_lane_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (lane_done == '0))
    else $error("lane finished with no frame in flight");

  a_merge_state: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> (state_r == S_MERGE))
    else $error("merge finished outside merge phase");

  a_seen_cal_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.line_seen) |-> !out_r.calibration_error)
    else $error("line seen reported with bad calibration");

endmodule

/* verif/line_position_estimator_top_tb.sv */
// self-checking testbench of the line position estimator top level
`timescale 1ns / 1ps
module line_position_estimator_top_tb;
  import lpe_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  line_position_estimator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and calibration store
  logic [11:0] mdl_line, mdl_track, mdl_thresh;
  logic        mdl_light;
  logic [11:0] mdl_min [8];
  logic [11:0] mdl_max [8];
  int          mdl_last;

  out_t pending_results [$];
  int   error_count;
  bit   stall_hold;   // receiver hold-off request
  bit   quiet_mode;   // no random idling while set

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #40ms;
    $display("line_position_estimator_top verification failed");
    $finish;
  end

  function automatic logic [11:0] frame_sample(in_t d, int i);
    case (i)
      0: return d.sample_0;
      1: return d.sample_1;
      2: return d.sample_2;
      3: return d.sample_3;
      4: return d.sample_4;
      5: return d.sample_5;
      6: return d.sample_6;
      default: return d.sample_7;
    endcase
  endfunction

  function automatic bit cal_invalid();
    for (int i = 0; i < 8; i++)
      if (mdl_min[i] >= mdl_max[i]) return 1'b1;
    return 1'b0;
  endfunction

  // predicted position, seen flag and calibration flag for one frame
  function automatic out_t predict_position(in_t d);
    out_t   r;
    longint lo, hi, a, b, v, sum, total, w;
    bit     seen;
    logic [11:0] s;
    seen = 0;
    case (d.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < 8; i++) begin
          mdl_min[i] = 12'hfff;
          mdl_max[i] = 12'h000;
        end
      end
      OP_TRACK: begin
        for (int i = 0; i < 8; i++) begin
          s = frame_sample(d, i);
          if (s > mdl_max[i]) mdl_max[i] = s;
          if (s < mdl_min[i]) mdl_min[i] = s;
        end
      end
      OP_LOAD_MAX: for (int i = 0; i < 8; i++) mdl_max[i] = frame_sample(d, i);
      OP_LOAD_MIN: for (int i = 0; i < 8; i++) mdl_min[i] = frame_sample(d, i);
      OP_MEASURE: begin
        if (!cal_invalid()) begin
          sum = 0;
          total = 0;
          a = mdl_light ? longint'(mdl_track) : longint'(mdl_line);
          b = mdl_light ? longint'(mdl_line) : longint'(mdl_track);
          for (int i = 0; i < 8; i++) begin
            lo = mdl_min[i];
            hi = mdl_max[i];
            v = (longint'(frame_sample(d, i)) - lo) * (b - a) / (hi - lo) + a;
            if (v < longint'(mdl_track)) v = mdl_track;
            if (v > longint'(mdl_line)) v = mdl_line;
            w = 3500 - 1000 * i;
            sum += v * w;
            total += v;
            if (v > longint'(mdl_thresh)) seen = 1;
          end
          if (seen && total > 0) mdl_last = int'(sum / total);
          else begin
            // saturate toward the nearer end, tie goes to the last weight
            seen = 0;
            if ((mdl_last > 3500 ? mdl_last - 3500 : 3500 - mdl_last) <
                (mdl_last + 3500 < 0 ? -(mdl_last + 3500) : mdl_last + 3500))
              mdl_last = 3500;
            else
              mdl_last = -3500;
          end
        end
      end
      default: ;
    endcase
    r.position = 13'(mdl_last);
    r.line_seen = seen;
    r.calibration_error = cal_invalid();
    return r;
  endfunction

  // receiver: random ready, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (stall_hold) out_ready <= 1'b0;
    else if (quiet_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 19);
  end

  // result checker, compares each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, out_data);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.position !== exp_r.position) begin
          $display("%0t: position expected %0d actual %0d", $time,
                   exp_r.position, out_data.position);
          error_count++;
        end
        if (out_data.line_seen !== exp_r.line_seen) begin
          $display("%0t: line_seen expected %0b actual %0b", $time,
                   exp_r.line_seen, out_data.line_seen);
          error_count++;
        end
        if (out_data.calibration_error !== exp_r.calibration_error) begin
          $display("%0t: calibration_error expected %0b actual %0b", $time,
                   exp_r.calibration_error, out_data.calibration_error);
          error_count++;
        end
      end
    end
  end

  // send one frame; expectation is recorded at the accepting edge
  // valid stays up after the transaction until an idle cycle or the next frame
  task automatic send_frame(in_t d);
    if (!quiet_mode)
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_position(d));
  endtask

  task automatic send_op(logic [2:0] op, logic [11:0] s0, logic [11:0] s1, logic [11:0] s2,
                         logic [11:0] s3, logic [11:0] s4, logic [11:0] s5,
                         logic [11:0] s6, logic [11:0] s7);
    in_t d;
    d = '{op, s0, s1, s2, s3, s4, s5, s6, s7};
    send_frame(d);
  endtask

  function automatic in_t random_frame(logic [2:0] op, int lo, int hi);
    in_t d;
    d.opcode = op;
    d.sample_0 = 12'($urandom_range(hi, lo));
    d.sample_1 = 12'($urandom_range(hi, lo));
    d.sample_2 = 12'($urandom_range(hi, lo));
    d.sample_3 = 12'($urandom_range(hi, lo));
    d.sample_4 = 12'($urandom_range(hi, lo));
    d.sample_5 = 12'($urandom_range(hi, lo));
    d.sample_6 = 12'($urandom_range(hi, lo));
    d.sample_7 = 12'($urandom_range(hi, lo));
    return d;
  endfunction

  // wait until every result is back, then let the measure pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // register write while idle; valid stays up for the next write
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LINE_LEVEL:     mdl_line = val;
      CFG_TRACK_LEVEL:    mdl_track = val;
      CFG_LINE_THRESHOLD: mdl_thresh = val;
      CFG_LINE_IS_LIGHT:  mdl_light = val[0];
      default: ;
    endcase
  endtask

  task automatic set_levels(int ln, int tr, int th, int lt);
    wait_idle();
    write_reg(CFG_LINE_LEVEL, 12'(ln));
    write_reg(CFG_TRACK_LEVEL, 12'(tr));
    write_reg(CFG_LINE_THRESHOLD, 12'(th));
    write_reg(CFG_LINE_IS_LIGHT, 12'(lt));
    cfg_valid <= 1'b0;
  endtask

  // directed: every opcode, unused opcodes, bad calibration, extremes, no line
  task automatic test_directed();
    send_op(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0);            // bad calibration at reset
    send_op(3'd5, 12'hfff, 0, 0, 0, 0, 0, 0, 0);
    send_op(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(3'd7, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_op(OP_TRACK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_TRACK, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_op(OP_MEASURE, 12'hfff, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 12'hfff);
    send_op(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0);             // line everywhere (dark)
    send_op(OP_MEASURE, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
            12'hfff);                                         // no line seen
    send_op(OP_MEASURE, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
            12'hfff);
    send_op(OP_LOAD_MAX, 100, 200, 300, 400, 500, 600, 700, 800);
    send_op(OP_LOAD_MIN, 100, 0, 0, 0, 0, 0, 0, 0);          // min equals max
    send_op(OP_MEASURE, 50, 60, 70, 80, 90, 100, 110, 120);
    send_op(OP_LOAD_MIN, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_MEASURE, 0, 200, 300, 400, 500, 600, 700, 800);
    send_op(OP_MEASURE, 4000, 4000, 0, 0, 0, 0, 0, 0);      // samples above max
    send_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_MEASURE, 1, 2, 3, 4, 5, 6, 7, 8);
    // levels crossed: track above line
    set_levels(100, 4095, 50, 1);
    send_op(OP_LOAD_MAX, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 12'hfff,
            12'hfff);
    send_op(OP_LOAD_MIN, 0, 0, 0, 0, 0, 0, 0, 0);
    send_op(OP_MEASURE, 12'hfff, 0, 12'h800, 0, 0, 0, 0, 0);
    set_levels(4095, 0, 0, 1);
    send_op(OP_MEASURE, 12'hfff, 0, 0, 0, 0, 0, 0, 12'hfff);
    set_levels(4095, 0, 4095, 0);
    send_op(OP_MEASURE, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  // random: mostly calibrate then measure, with some noise
  task automatic test_random(int count);
    in_t d;
    int  lo;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0: d = random_frame(OP_CLEAR, 0, 4095);
        1, 2: d = random_frame(OP_TRACK, 0, 4095);
        3: d = random_frame(OP_LOAD_MAX, 2048, 4095);
        4: d = random_frame(OP_LOAD_MIN, 0, 2047);
        5: d = random_frame(3'($urandom_range(7)), 0, 4095);
        default: begin
          lo = $urandom_range(1) ? 0 : 1000;
          d = random_frame(OP_MEASURE, lo, 4095);
        end
      endcase
      send_frame(d);
    end
  endtask

  task automatic test_random_settings();
    set_levels(1000, 0, 700, 0);
    test_random(300);
    set_levels(4095, 0, 2000, 1);
    test_random(300);
    set_levels($urandom_range(4095), $urandom_range(1000), $urandom_range(4095),
               $urandom_range(1));
    test_random(300);
    set_levels(0, 0, 0, 0);
    test_random(100);
    set_levels(2500, 300, $urandom_range(2500), 1);
    quiet_mode = 1;            // stretch with no idling
    test_random(200);
    quiet_mode = 0;
  endtask

  // receiver holds off while the sender keeps offering frames
  task automatic test_backpressure();
    fork
      begin
        stall_hold = 1;
        repeat (3000) @(posedge clk);
        stall_hold = 0;
      end
      test_random(150);
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_hold = 0;
    quiet_mode = 0;
    error_count = 0;
    mdl_line = 1000;
    mdl_track = 0;
    mdl_thresh = 700;
    mdl_light = 0;
    mdl_last = 0;
    for (int i = 0; i < 8; i++) begin
      mdl_min[i] = 12'hfff;
      mdl_max[i] = 12'h000;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_settings();
    test_backpressure();

    wait_idle();
    if (error_count == 0)
      $display("line_position_estimator_top verification clean");
    else
      $display("line_position_estimator_top verification failed");
    $finish;
  end

endmodule

/* line_position_estimator_top.f */
rtl/lpe_pkg.sv
rtl/lpe_div.sv
rtl/lpe_lane.sv
rtl/lpe_merge.sv
rtl/line_position_estimator_top.sv
verif/line_position_estimator_top_tb.sv
